[sv/jps_pkg.sv]
// jps_pkg: shared constants and types of the jacobi poisson stencil
// no dependencies; imported by every module of the block but jps_ram

package jps_pkg;

    localparam int DEF_MAX_COLS   = 128;
    localparam int DEF_MAX_ROWS   = 128;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int FRAC_W  = 16;
    localparam int COORD_W = 7;
    localparam int DIM_W   = 8;
    localparam int CFG_W   = 32;
    localparam int PADDR_W = 5;
    localparam int MIN_DIM = 3;

    localparam logic [DIM_W-1:0] DIM_RST      = 8'd100;
    localparam logic [CFG_W-1:0] COEF_P_RST   = 32'd16384;
    localparam logic [CFG_W-1:0] COEF_DIV_RST = 32'd0;

    // config register index, byte address is four times the index
    typedef enum logic [2:0] {
        REG_GRID_WIDTH,
        REG_GRID_HEIGHT,
        REG_COEF_EW,
        REG_COEF_NS,
        REG_COEF_DX,
        REG_COEF_DY
    } t_reg_idx;

    typedef struct packed {
        logic sub;
        logic load_sum;
        logic load_term;
    } t_lane_ctl;

endpackage

[sv/jps_ram.sv]
// jps_ram: generic line buffer ram, one write port, two registered read ports
// depends on nothing but its parameters

module jps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[sv/jps_lane.sv]
// jps_lane: one stencil term cell, operand sum or difference then scaled product
// depends on jps_pkg (lane control struct, fraction width)

module jps_lane import jps_pkg::*; #(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                                i_clk,
    input  t_lane_ctl                           i_ctl,
    input  logic signed [DATA_WIDTH-1:0]        i_coef,
    input  logic signed [DATA_WIDTH-1:0]        i_x,
    input  logic signed [DATA_WIDTH-1:0]        i_y,
    output logic signed [2*DATA_WIDTH-FRAC_W:0] o_term
);

    logic signed [DATA_WIDTH:0]          r_sum;
    logic signed [2*DATA_WIDTH:0]        prod;
    logic signed [2*DATA_WIDTH-FRAC_W:0] r_term;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_sum) begin
            if (i_ctl.sub) begin
                r_sum <= {i_x[DATA_WIDTH-1], i_x} - {i_y[DATA_WIDTH-1], i_y};
            end else begin
                r_sum <= {i_x[DATA_WIDTH-1], i_x} + {i_y[DATA_WIDTH-1], i_y};
            end
        end
        if (i_ctl.load_term) begin
            r_term <= prod[2*DATA_WIDTH:FRAC_W];
        end
    end

    // exact product, floor by dropping the fraction bits
    assign prod   = i_coef * r_sum;
    assign o_term = r_term;

endmodule

[sv/jacobi_poisson_stencil.sv]
// jacobi_poisson_stencil: top level, config registers, line buffers, term cells
// depends on jps_pkg, jps_ram and jps_lane
//
// usage
//   grid points come in on the request channel (i_valid / o_ready) in raster
//   order, row 0 first, each with old pressure, x velocity and y velocity
//   results leave on o_valid / i_ready, one per interior point, with its row,
//   column and a last flag on the final interior point of the grid
//   a point of row r column c (r >= 2, 1 <= c <= width-2) yields interior
//   point (r-1, c); border points only fill the line buffers
//   throughput is one request per cycle while results are taken; the line
//   buffer rams are read one request ahead at the next column and the one after
//   it, so no stall is needed; an accepted point reaches o_valid through four
//   registers (operand sum, product, pair add, final add with saturation)
//   a stalled receiver holds the output register; the pipeline keeps taking
//   requests until every stage is full, then o_ready drops
//   reset clears the counters, the pipeline valids and the config registers;
//   the line buffers are not cleared, rows 0 and 1 of each frame fill them
//   config writes on the apb port take effect at once and belong between
//   requests with the pipeline empty

module jacobi_poisson_stencil import jps_pkg::*; #(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [PADDR_W-1:0]           paddr,
    input  logic [CFG_W-1:0]             pwdata,
    output logic [CFG_W-1:0]             prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [DATA_WIDTH-1:0] i_p_old,
    input  logic signed [DATA_WIDTH-1:0] i_u_vel,
    input  logic signed [DATA_WIDTH-1:0] i_v_vel,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_p_new,
    output logic [COORD_W-1:0]           o_row,
    output logic [COORD_W-1:0]           o_col,
    output logic                         o_last
);

    localparam int DW = DATA_WIDTH;
    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int WW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
    localparam int HW = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;
    localparam int TW = 2 * DW + 1 - FRAC_W;
    localparam int SW = TW + 2;

    localparam logic signed [SW-1:0] SAT_HI = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

    // config registers
    logic [DIM_W-1:0] r_grid_width;
    logic [DIM_W-1:0] r_grid_height;
    logic [CFG_W-1:0] r_coef_ew;
    logic [CFG_W-1:0] r_coef_ns;
    logic [CFG_W-1:0] r_coef_dx;
    logic [CFG_W-1:0] r_coef_dy;
    logic             cfg_wr;
    t_reg_idx         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= DIM_RST;
            r_grid_height <= DIM_RST;
            r_coef_ew     <= COEF_P_RST;
            r_coef_ns     <= COEF_P_RST;
            r_coef_dx     <= COEF_DIV_RST;
            r_coef_dy     <= COEF_DIV_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_GRID_WIDTH:  r_grid_width  <= pwdata[DIM_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= pwdata[DIM_W-1:0];
                REG_COEF_EW:     r_coef_ew     <= pwdata;
                REG_COEF_NS:     r_coef_ns     <= pwdata;
                REG_COEF_DX:     r_coef_dx     <= pwdata;
                REG_COEF_DY:     r_coef_dy     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_GRID_WIDTH:  prdata = CFG_W'(r_grid_width);
            REG_GRID_HEIGHT: prdata = CFG_W'(r_grid_height);
            REG_COEF_EW:     prdata = r_coef_ew;
            REG_COEF_NS:     prdata = r_coef_ns;
            REG_COEF_DX:     prdata = r_coef_dx;
            REG_COEF_DY:     prdata = r_coef_dy;
            default:         prdata = '0;
        endcase
    end

    // effective grid size
    logic [WW-1:0] gw;
    logic [WW-1:0] w_dim;
    logic [HW-1:0] gh;
    logic [HW-1:0] h_dim;

    assign gw    = WW'(r_grid_width);
    assign gh    = HW'(r_grid_height);
    assign w_dim = (gw < WW'(MIN_DIM)) ? WW'(MIN_DIM) :
                   (gw > WW'(MAX_COLS)) ? WW'(MAX_COLS) : gw;
    assign h_dim = (gh < HW'(MIN_DIM)) ? HW'(MIN_DIM) :
                   (gh > HW'(MAX_ROWS)) ? HW'(MAX_ROWS) : gh;

    // pipeline handshake
    logic r_v1, r_v2, r_v3, r_out_valid;
    logic en1, en2, en3, en4;
    logic acc;

    assign en4     = !r_out_valid || i_ready;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign acc     = i_valid && en1;

    // raster position
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [WW-1:0] col_ext;
    logic [HW-1:0] row_ext;
    logic          col_wrap, row_wrap;
    logic          emit, at_last;

    assign col_ext  = WW'(r_col);
    assign row_ext  = HW'(r_row);
    assign col_wrap = (col_ext + WW'(1)) >= w_dim;
    assign row_wrap = (row_ext + HW'(1)) >= h_dim;
    assign n_col    = col_wrap ? '0 : r_col + CW'(1);
    assign n_row    = col_wrap ? (row_wrap ? '0 : r_row + RW'(1)) : r_row;
    assign emit     = (row_ext >= HW'(2)) && (row_ext < h_dim) &&
                      (r_col != '0) && ((col_ext + WW'(2)) <= w_dim);
    assign at_last  = ((row_ext + HW'(1)) == h_dim) && ((col_ext + WW'(2)) == w_dim);

    // line buffers, read one request ahead at the center and east column
    logic [CW-1:0]     rd_col, rd_lead;
    logic              par;
    logic [2*DW-1:0]   pv_rd_a [2];
    logic [2*DW-1:0]   pv_rd_b [2];
    logic [DW-1:0]     u_rd_a, u_rd_b;

    assign rd_col  = acc ? n_col : r_col;
    assign rd_lead = rd_col + CW'(1);
    assign par     = r_row[0];

    for (genvar k = 0; k < 2; k++) begin : g_pv_line
        jps_ram #(
            .WIDTH (2 * DW),
            .DEPTH (MAX_COLS)
        ) u_pv_ram (
            .i_clk     (i_clk),
            .i_we      (acc && (r_row[0] == 1'(k))),
            .i_waddr   (r_col),
            .i_wdata   ({i_v_vel, i_p_old}),
            .i_raddr_a (rd_lead),
            .i_raddr_b (rd_col),
            .o_rdata_a (pv_rd_a[k]),
            .o_rdata_b (pv_rd_b[k])
        );
    end

    jps_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_COLS)
    ) u_u_ram (
        .i_clk     (i_clk),
        .i_we      (acc),
        .i_waddr   (r_col),
        .i_wdata   (i_u_vel),
        .i_raddr_a (rd_lead),
        .i_raddr_b (rd_col),
        .o_rdata_a (u_rd_a),
        .o_rdata_b (u_rd_b)
    );

    logic signed [DW-1:0] p_east, p_ctr, p_south, v_south, u_east, u_ctr;
    logic signed [DW-1:0] r_p_west, r_u_west;

    assign p_east  = pv_rd_a[~par][DW-1:0];
    assign p_ctr   = pv_rd_b[~par][DW-1:0];
    assign p_south = pv_rd_b[par][DW-1:0];
    assign v_south = pv_rd_b[par][2*DW-1:DW];
    assign u_east  = u_rd_a;
    assign u_ctr   = u_rd_b;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_p_west <= p_ctr;
            r_u_west <= u_ctr;
        end
    end

    // term cells
    logic signed [DW-1:0] cx, cy, kx, ky;
    t_lane_ctl            ctl_add, ctl_sub;
    logic signed [TW-1:0] t_ew, t_ns, t_dx, t_dy;

    assign cx = DW'(r_coef_ew);
    assign cy = DW'(r_coef_ns);
    assign kx = DW'(r_coef_dx);
    assign ky = DW'(r_coef_dy);

    assign ctl_add = '{sub: 1'b0, load_sum: en1, load_term: en2};
    assign ctl_sub = '{sub: 1'b1, load_sum: en1, load_term: en2};

    jps_lane #(.DATA_WIDTH(DW)) u_lane_ew (
        .i_clk (i_clk), .i_ctl (ctl_add), .i_coef (cx),
        .i_x (p_east), .i_y (r_p_west), .o_term (t_ew)
    );
    jps_lane #(.DATA_WIDTH(DW)) u_lane_ns (
        .i_clk (i_clk), .i_ctl (ctl_add), .i_coef (cy),
        .i_x (i_p_old), .i_y (p_south), .o_term (t_ns)
    );
    jps_lane #(.DATA_WIDTH(DW)) u_lane_dx (
        .i_clk (i_clk), .i_ctl (ctl_sub), .i_coef (kx),
        .i_x (u_east), .i_y (r_u_west), .o_term (t_dx)
    );
    jps_lane #(.DATA_WIDTH(DW)) u_lane_dy (
        .i_clk (i_clk), .i_ctl (ctl_sub), .i_coef (ky),
        .i_x (i_v_vel), .i_y (v_south), .o_term (t_dy)
    );

    // pair sums, final sum and saturation
    logic signed [TW:0]    r_pa, r_pb;
    logic signed [SW-1:0]  tot;
    logic signed [DW-1:0]  p_sat;
    logic [COORD_W-1:0]    r_row1, r_col1, r_row2, r_col2, r_row3, r_col3;
    logic                  r_last1, r_last2, r_last3;
    logic signed [DW-1:0]  r_out_p;
    logic [COORD_W-1:0]    r_out_row, r_out_col;
    logic                  r_out_last;

    assign tot   = {r_pa[TW], r_pa} - {r_pb[TW], r_pb};
    assign p_sat = (tot > SAT_HI) ? SAT_HI[DW-1:0] :
                   (tot < SAT_LO) ? SAT_LO[DW-1:0] : tot[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (en1) begin
                r_v1 <= acc && emit;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_out_valid <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_row1  <= COORD_W'(r_row - RW'(1));
            r_col1  <= COORD_W'(r_col);
            r_last1 <= at_last;
        end
        if (en2) begin
            r_row2  <= r_row1;
            r_col2  <= r_col1;
            r_last2 <= r_last1;
        end
        if (en3) begin
            r_pa    <= {t_ew[TW-1], t_ew} + {t_ns[TW-1], t_ns};
            r_pb    <= {t_dx[TW-1], t_dx} + {t_dy[TW-1], t_dy};
            r_row3  <= r_row2;
            r_col3  <= r_col2;
            r_last3 <= r_last2;
        end
        if (en4) begin
            r_out_p    <= p_sat;
            r_out_row  <= r_row3;
            r_out_col  <= r_col3;
            r_out_last <= r_last3;
        end
    end

    assign o_valid = r_out_valid;
    assign o_p_new = r_out_p;
    assign o_row   = r_out_row;
    assign o_col   = r_out_col;
    assign o_last  = r_out_last;

endmodule

[sv/jps_checker.sv]
// jps_checker: port level assertions on the result channel of the stencil
// depends on jps_pkg; bound to jacobi_poisson_stencil at the end of this file

module jps_checker import jps_pkg::*; #(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic signed [DATA_WIDTH-1:0] o_p_new,
    input logic [COORD_W-1:0]           o_row,
    input logic [COORD_W-1:0]           o_col,
    input logic                         o_last
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_p_new) && $stable(o_row)
            && $stable(o_col) && $stable(o_last))
        else $error("stalled result changed");

    // only interior points are reported
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_row != '0) && (o_col != '0))
        else $error("border point reported");

endmodule

bind jacobi_poisson_stencil jps_checker #(.DATA_WIDTH(DATA_WIDTH)) u_jps_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_p_new (o_p_new),
    .o_row   (o_row),
    .o_col   (o_col),
    .o_last  (o_last)
);

[verif/jacobi_poisson_stencil_test.sv]
// jacobi_poisson_stencil_test: self-checking testbench of the jacobi poisson stencil
// depends on jps_pkg and jacobi_poisson_stencil; keeps its own line buffers and
// window, predicts every interior point and checks the results in order

module jacobi_poisson_stencil_test import jps_pkg::*;;

    localparam int DW   = DEF_DATA_WIDTH;
    localparam int NCOL = DEF_MAX_COLS;
    localparam int NROW = DEF_MAX_ROWS;

    localparam logic [DW-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic signed [79:0] SAT_HI = 80'sh7FFF_FFFF;
    localparam logic signed [79:0] SAT_LO = -80'sh8000_0000;

    typedef struct {
        logic [DW-1:0]      p_new;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } t_stencil_out;

    logic                         i_clk   = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         psel    = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite  = 1'b0;
    logic [PADDR_W-1:0]           paddr   = '0;
    logic [CFG_W-1:0]             pwdata  = '0;
    logic [CFG_W-1:0]             prdata;
    logic                         pready;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic signed [DW-1:0]         i_p_old = '0;
    logic signed [DW-1:0]         i_u_vel = '0;
    logic signed [DW-1:0]         i_v_vel = '0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic signed [DW-1:0]         o_p_new;
    logic [COORD_W-1:0]           o_row;
    logic [COORD_W-1:0]           o_col;
    logic                         o_last;

    // mirror of the block: registers, line buffers, window and position
    logic [DIM_W-1:0]     grid_w_reg = DIM_RST;
    logic [DIM_W-1:0]     grid_h_reg = DIM_RST;
    logic signed [DW-1:0] coef_ew = COEF_P_RST;
    logic signed [DW-1:0] coef_ns = COEF_P_RST;
    logic signed [DW-1:0] coef_dx = COEF_DIV_RST;
    logic signed [DW-1:0] coef_dy = COEF_DIV_RST;
    logic signed [DW-1:0] p_rows [2][NCOL];
    logic signed [DW-1:0] u_row [NCOL];
    logic signed [DW-1:0] v_rows [2][NCOL];
    logic signed [DW-1:0] u_west = '0;
    int unsigned          at_row = 0;
    int unsigned          at_col = 0;

    t_stencil_out pending_points[$];
    t_stencil_out want_point;
    int           mismatches = 0;
    int           send_gap_pct = 0;
    int           recv_stall_pct = 0;

    jacobi_poisson_stencil DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_p_old (i_p_old),
        .i_u_vel (i_u_vel),
        .i_v_vel (i_v_vel),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_p_new (o_p_new),
        .o_row   (o_row),
        .o_col   (o_col),
        .o_last  (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int unsigned dim_in_use(int unsigned v, int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void advance(inout int unsigned r, inout int unsigned c);
        if (c + 1 >= dim_in_use(grid_w_reg, NCOL)) begin
            c = 0;
            r = (r + 1 >= dim_in_use(grid_h_reg, NROW)) ? 0 : ((r + 1) & 'h7F);
        end else begin
            c = (c + 1) & 'h7F;
        end
    endfunction

    function automatic int points_to_frame_end();
        int unsigned r;
        int unsigned c;
        int          n;
        r = at_row;
        c = at_col;
        n = 0;
        do begin
            advance(r, c);
            n++;
        end while (r != 0 || c != 0);
        return n;
    endfunction

    // floor(k * s / 2^16) with the product kept exact
    function automatic logic signed [79:0] q16_term(logic signed [DW-1:0] k,
                                                    logic signed [DW:0] s);
        logic signed [79:0] prod;
        prod = k * s;
        return prod >>> FRAC_W;
    endfunction

    function automatic void predict_sweep_point(logic signed [DW-1:0] p,
                                                logic signed [DW-1:0] u,
                                                logic signed [DW-1:0] v);
        int unsigned          w;
        int unsigned          h;
        int unsigned          r;
        int unsigned          c;
        int unsigned          cur;
        int unsigned          prv;
        int unsigned          ce;
        logic signed [DW-1:0] u_above;
        logic signed [DW:0]   s_ew;
        logic signed [DW:0]   s_ns;
        logic signed [DW:0]   s_dx;
        logic signed [DW:0]   s_dy;
        logic signed [79:0]   acc;
        t_stencil_out         res;
        w = dim_in_use(grid_w_reg, NCOL);
        h = dim_in_use(grid_h_reg, NROW);
        r = at_row;
        c = at_col % NCOL;
        cur = r & 1;
        prv = cur ^ 1;
        u_above = u_row[c];
        if (r >= 2 && r <= h - 1 && c >= 1 && c + 2 <= w) begin
            ce = (c + 1) % NCOL;
            s_ew = p_rows[prv][ce] + p_rows[prv][c-1];
            s_ns = p + p_rows[cur][c];
            s_dx = u_row[ce] - u_west;
            s_dy = v - v_rows[cur][c];
            acc = q16_term(coef_ew, s_ew) + q16_term(coef_ns, s_ns)
                - q16_term(coef_dx, s_dx) - q16_term(coef_dy, s_dy);
            if (acc > SAT_HI) res.p_new = WORD_MAX;
            else if (acc < SAT_LO) res.p_new = WORD_MIN;
            else res.p_new = acc[DW-1:0];
            res.row = COORD_W'(r - 1);
            res.col = COORD_W'(c);
            res.last = (r == h - 1 && c == w - 2);
            pending_points.push_back(res);
        end
        u_west = u_above;
        p_rows[cur][c] = p;
        u_row[c] = u;
        v_rows[cur][c] = v;
        advance(at_row, at_col);
    endfunction

    function automatic logic [DW-1:0] rand_word();
        case ($urandom_range(9))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return '1;
            4, 5: return $urandom;
            default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [DW-1:0] got, logic [DW-1:0] want,
                               t_stencil_out at);
        if (got !== want)
            report_mismatch($sformatf("%s of point (%0d,%0d): got %h want %h",
                                      name, at.row, at.col, got, want));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_points.size() == 0) begin
                report_mismatch($sformatf("unexpected result row %0d col %0d", o_row, o_col));
            end else begin
                want_point = pending_points.pop_front();
                check_field("p_new", o_p_new, want_point.p_new, want_point);
                check_field("row", DW'(o_row), DW'(want_point.row), want_point);
                check_field("col", DW'(o_col), DW'(want_point.col), want_point);
                check_field("last", DW'(o_last), DW'(want_point.last), want_point);
            end
        end
    end

    task automatic cfg_write(t_reg_idx idx, logic [CFG_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(int'(idx) * 4);
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_GRID_WIDTH:  grid_w_reg = val[DIM_W-1:0];
            REG_GRID_HEIGHT: grid_h_reg = val[DIM_W-1:0];
            REG_COEF_EW:     coef_ew = val;
            REG_COEF_NS:     coef_ns = val;
            REG_COEF_DX:     coef_dx = val;
            REG_COEF_DY:     coef_dy = val;
            default: ;
        endcase
    endtask

    // one request, held until accepted
    task automatic send_point(logic [DW-1:0] p, logic [DW-1:0] u, logic [DW-1:0] v);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_p_old <= p;
        i_u_vel <= u;
        i_v_vel <= v;
        do @(posedge i_clk); while (!o_ready);
        predict_sweep_point(p, u, v);
    endtask

    task automatic send_points(int n);
        repeat (n) send_point(rand_word(), rand_word(), rand_word());
    endtask

    task automatic settle_pipeline();
        i_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic test_register_reset();
        logic [CFG_W-1:0] want_regs [6];
        want_regs = '{CFG_W'(DIM_RST), CFG_W'(DIM_RST), COEF_P_RST, COEF_P_RST,
                      COEF_DIV_RST, COEF_DIV_RST};
        for (int i = 0; i < 6; i++) begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b0;
            paddr <= PADDR_W'(i * 4);
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            if (prdata !== want_regs[i])
                report_mismatch($sformatf("register %0d reads %h want %h",
                                          i, prdata, want_regs[i]));
            psel <= 1'b0;
            penable <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // widest grid first so every line buffer entry holds data
    task automatic test_line_fill();
        cfg_write(REG_GRID_WIDTH, 32'd255);
        cfg_write(REG_GRID_HEIGHT, 32'd3);
        send_points(points_to_frame_end());
        settle_pipeline();
    endtask

    task automatic directed_frame(bit flip);
        int w;
        int h;
        w = dim_in_use(grid_w_reg, NCOL);
        h = dim_in_use(grid_h_reg, NROW);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                send_point(flip ? WORD_MIN : WORD_MAX,
                           ((c > 1) ^ flip) ? WORD_MAX : WORD_MIN,
                           ((r > 1) ^ flip) ? WORD_MAX : WORD_MIN);
        settle_pipeline();
    endtask

    task automatic test_directed_extremes();
        cfg_write(REG_GRID_WIDTH, 32'd0);
        cfg_write(REG_GRID_HEIGHT, 32'd2);
        cfg_write(REG_COEF_EW, WORD_MAX);
        cfg_write(REG_COEF_NS, WORD_MAX);
        cfg_write(REG_COEF_DX, WORD_MIN);
        cfg_write(REG_COEF_DY, WORD_MIN);
        directed_frame(1'b0);
        cfg_write(REG_GRID_WIDTH, 32'd4);
        cfg_write(REG_GRID_HEIGHT, 32'd3);
        directed_frame(1'b1);
    endtask

    task automatic test_size_limits();
        cfg_write(REG_GRID_WIDTH, 32'd3);
        cfg_write(REG_GRID_HEIGHT, 32'd200);
        cfg_write(REG_COEF_EW, 32'h0000_4000);
        cfg_write(REG_COEF_NS, 32'h0000_4000);
        cfg_write(REG_COEF_DX, 32'h0000_0800);
        cfg_write(REG_COEF_DY, 32'hFFFF_F800);
        send_points(points_to_frame_end());
        settle_pipeline();
    endtask

    // whole frames mostly; some stop part way so the next sizes land mid-frame
    task automatic test_random_stream(int target);
        int                 sent;
        int                 n;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        sent = 0;
        while (sent < target) begin
            settle_pipeline();
            if ($urandom_range(3) != 0) begin
                case ($urandom_range(19))
                    0: begin
                        w = $urandom_range(2);
                        h = $urandom_range(6);
                    end
                    1: begin
                        w = $urandom_range(1) ? 8'd128 : DIM_W'($urandom_range(129, 255));
                        h = $urandom_range(4);
                    end
                    2: begin
                        w = $urandom_range(4);
                        h = $urandom_range(100, 255);
                    end
                    default: begin
                        w = $urandom_range(3, 14);
                        h = $urandom_range(3, 10);
                    end
                endcase
                cfg_write(REG_GRID_WIDTH, {24'($urandom), w});
                cfg_write(REG_GRID_HEIGHT, {24'($urandom), h});
            end
            if ($urandom_range(1)) cfg_write(REG_COEF_EW, rand_word());
            if ($urandom_range(1)) cfg_write(REG_COEF_NS, rand_word());
            if ($urandom_range(1)) cfg_write(REG_COEF_DX, rand_word());
            if ($urandom_range(1)) cfg_write(REG_COEF_DY, rand_word());
            n = points_to_frame_end();
            if ($urandom_range(5) == 0 && n > 1) n = $urandom_range(1, n - 1);
            send_points(n);
            sent += n;
        end
        settle_pipeline();
    endtask

    initial begin
        send_gap_pct = 28;
        recv_stall_pct = 88;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_reset();
        test_line_fill();
        test_directed_extremes();
        test_size_limits();
        test_random_stream(300);
        send_gap_pct = 88;
        recv_stall_pct = 28;
        test_random_stream(350);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        test_random_stream(450);
        if (mismatches == 0) begin
            $display("jacobi_poisson_stencil_test passed");
        end else begin
            $display("jacobi_poisson_stencil_test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("jacobi_poisson_stencil_test failed");
        $finish;
    end

endmodule

[filelist.f]
sv/jps_pkg.sv
sv/jps_ram.sv
sv/jps_lane.sv
sv/jacobi_poisson_stencil.sv
sv/jps_checker.sv
verif/jacobi_poisson_stencil_test.sv
